### rtl/acd_pkg.sv
// Shared types, constants and helpers for the ADC channel average scaler.
// Used by every module under rtl/; depends on nothing else.
`default_nettype none

package acd_pkg;

  localparam int ADC_BITS  = 12;
  localparam int SLOTS_DEF = 8;
  localparam int SLOT_W    = 3;
  localparam int KIND_W    = 3;
  localparam int SUM_W     = 20;
  localparam int CNT_W     = 8;
  localparam int GAIN_W    = 32;
  localparam int VAL_W     = 48;
  localparam int REFMV_W   = 16;
  localparam int CODE_W    = 12;
  localparam int PADDR_W   = 4;
  localparam int PDATA_W   = 32;

  // Shared divider: widest dividend is mean*ref_mv<<16, widest divisor 1000*full scale.
  localparam int DIVD_W = 44;
  localparam int DIVR_W = 22;
  localparam int MUL_A_W = 34;
  localparam int MUL_P_W = 66;

  localparam logic [ADC_BITS-1:0] FULL_SCALE = '1;
  localparam logic [DIVR_W-1:0] VOLT_DIV = DIVR_W'(1000 * ((1 << ADC_BITS) - 1));
  localparam logic [DIVR_W-1:0] MV_DIV   = DIVR_W'(1000);
  localparam logic [REFMV_W-1:0] REFMV_RESET = REFMV_W'(3300);

  localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_LOAD   = 1'b1;

  localparam logic [1:0] REG_SPA   = 2'd0;
  localparam logic [1:0] REG_VCODE = 2'd1;
  localparam logic [1:0] REG_VCAL  = 2'd2;

  typedef enum logic [KIND_W-1:0] {
    KIND_CURRENT   = 3'd0,
    KIND_POS_RES   = 3'd1,
    KIND_NEG_RES   = 3'd2,
    KIND_VOLTAGE   = 3'd3,
    KIND_REFERENCE = 3'd4,
    KIND_RAW       = 3'd5
  } kind_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_UPD, ST_MEAN, ST_MUL1, ST_DIV2S, ST_DIV2W,
    ST_MUL2, ST_SCALE, ST_DIV3S, ST_DIV3W, ST_RES, ST_OUT
  } state_t;

  typedef enum logic [1:0] {DIV_MEAN, DIV_KIND, DIV_MV} div_sel_t;
  typedef enum logic {MUL_FIRST, MUL_OFFSET} mul_sel_t;

  typedef struct packed {
    logic                     command;
    logic [SLOT_W-1:0]        slot;
    logic [ADC_BITS-1:0]      sample;
    logic [KIND_W-1:0]        channel_kind;
    logic signed [GAIN_W-1:0] gain;
    logic signed [GAIN_W-1:0] offset_value;
  } item_t;

  typedef struct packed {
    logic [SLOT_W-1:0]       out_slot;
    logic signed [VAL_W-1:0] value;
    logic                    divide_fault;
  } result_t;

  typedef struct packed {
    logic [CNT_W-1:0]  samples_per_average;
    logic [CODE_W-1:0] vref_factory_code;
    logic [CODE_W-1:0] vref_cal_mv;
  } cfg_t;

  typedef struct packed {
    logic     take_item;
    logic     upd;
    logic     div_start;
    div_sel_t div_sel;
    logic     latch_m;
    logic     mul;
    mul_sel_t mul_sel;
    logic     latch_q2;
    logic     ref_update;
    logic     scale;
    logic     res_load;
    logic     out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic  slot_ok;
    logic  is_load;
    logic  avg_done;
    kind_t kind;
    logic  fault_now;
    logic  div_done;
    logic  out_free;
  } dp_status_t;

  function automatic logic signed [VAL_W-1:0] sat_val(input logic signed [63:0] x);
    logic signed [VAL_W-1:0] r;
    if (x > 64'(VAL_MAX)) r = VAL_MAX;
    else if (x < 64'(VAL_MIN)) r = VAL_MIN;
    else r = x[VAL_W-1:0];
    return r;
  endfunction

endpackage

`default_nettype wire

### rtl/adc_channel_average_scaler.sv
// Channel    Beat          Handshake                 Direction
// item       item_t        item_valid/item_stall     in
// result     result_t      result_valid/result_stall out
// config     APB 32 bit    psel/penable/pwrite       in
//
// A load beat or a sample that does not complete an average only passes the
// accept and update states. A completing sample passes the shared divider once
// (raw), twice (resistance, voltage, current) or three times (reference), and once
// if a divide fault is found first; these divider passes set its total time.
// One item is worked at a time; the next is taken once the result sits in
// the output register, which holds while result_stall is high.
// Reset (rst, synchronous) clears sums, counts, reference and control.
// Top level of the ADC channel average scaler; depends on acd_pkg and all rtl modules.
`default_nettype none

module adc_channel_average_scaler
  import acd_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               item_valid,
  output logic                    item_stall,
  input  wire item_t              item,
  output logic                    result_valid,
  input  wire logic               result_stall,
  output result_t                 result,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic      [PDATA_W-1:0] prdata,
  output logic                    pready
);

  cfg_t       cfg;
  dp_cmd_t    cmd;
  dp_status_t stat;

  acd_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  acd_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .stat       (stat),
    .cmd        (cmd)
  );

  acd_dp #(.SLOTS(SLOTS)) u_dp (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .cfg          (cfg),
    .cmd          (cmd),
    .stat         (stat),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

`default_nettype wire

### rtl/acd_regs.sv
// APB-style configuration registers of the ADC channel average scaler.
// Depends on acd_pkg.
`default_nettype none

module acd_regs
  import acd_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic      [PDATA_W-1:0] prdata,
  output logic                    pready,
  output cfg_t                    cfg
);

  logic wr;

  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.samples_per_average <= CNT_W'(5);
      cfg.vref_factory_code   <= CODE_W'(1650);
      cfg.vref_cal_mv         <= CODE_W'(3000);
    end else if (wr) begin
      case (paddr[3:2])
        REG_SPA:   cfg.samples_per_average <= pwdata[CNT_W-1:0];
        REG_VCODE: cfg.vref_factory_code   <= pwdata[CODE_W-1:0];
        REG_VCAL:  cfg.vref_cal_mv         <= pwdata[CODE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_SPA:   prdata = PDATA_W'(cfg.samples_per_average);
      REG_VCODE: prdata = PDATA_W'(cfg.vref_factory_code);
      REG_VCAL:  prdata = PDATA_W'(cfg.vref_cal_mv);
      default:   prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

### rtl/acd_div.sv
// Shared unsigned restoring divider, two quotient bits per cycle.
// Depends on acd_pkg for default widths.
`default_nettype none

module acd_div
  import acd_pkg::*;
#(
  parameter int DW = DIVD_W,
  parameter int RW = DIVR_W
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [DW-1:0] dividend,
  input  wire logic [RW-1:0] divisor,
  output logic               busy,
  output logic               done,
  output logic      [DW-1:0] quotient
);

  localparam int ITER  = DW / 2;
  localparam int ITW   = $clog2(ITER + 1);

  logic [RW-1:0]  rem, r1, r2;
  logic [DW-1:0]  quo, q1, q2;
  logic [RW-1:0]  dvs;
  logic [ITW-1:0] cnt;
  logic [RW:0]    t1, t2;
  logic           ge1, ge2;

  always_comb begin
    t1  = {rem, quo[DW-1]};
    ge1 = t1 >= {1'b0, dvs};
    r1  = ge1 ? RW'(t1 - {1'b0, dvs}) : t1[RW-1:0];
    q1  = {quo[DW-2:0], ge1};
    t2  = {r1, q1[DW-1]};
    ge2 = t2 >= {1'b0, dvs};
    r2  = ge2 ? RW'(t2 - {1'b0, dvs}) : t2[RW-1:0];
    q2  = {q1[DW-2:0], ge2};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= ITW'(ITER);
      end else if (busy) begin
        cnt <= cnt - ITW'(1);
        if (cnt == ITW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      rem <= r2;
      quo <= q2;
    end
  end

  assign quotient = quo;

endmodule

`default_nettype wire

### rtl/acd_dp.sv
// Datapath: slot tables, sums, multiplier, shared divider and result register.
// Depends on acd_pkg and acd_div.
`default_nettype none

module acd_dp
  import acd_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire item_t      item,
  input  wire cfg_t       cfg,
  input  wire dp_cmd_t    cmd,
  output dp_status_t      stat,
  output logic            result_valid,
  input  wire logic       result_stall,
  output result_t         result
);

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  logic [SUM_W-1:0]         sums  [SLOTS];
  logic [CNT_W-1:0]         cnts  [SLOTS];
  logic [KIND_W-1:0]        kinds [SLOTS];
  logic signed [GAIN_W-1:0] gains [SLOTS];
  logic signed [GAIN_W-1:0] offs  [SLOTS];

  item_t                    item_q;
  logic [IDX_W-1:0]         idx;
  logic [SUM_W-1:0]         newsum;
  logic [CNT_W-1:0]         newcnt, limit;
  kind_t                    kind_q;
  logic signed [GAIN_W-1:0] g_q, o_q;
  logic [ADC_BITS-1:0]      m;
  logic [ADC_BITS-1:0]      fs_minus_m;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [GAIN_W-1:0]  mul_b;
  logic signed [MUL_P_W-1:0] prod, p1, p1_mag;
  logic [DIVD_W-1:0]        q2;
  logic signed [63:0]       scaled, sh64, q64, o64, signed_q;
  logic                     fault_q, fault_now;
  logic signed [VAL_W-1:0]  res_val, res_val_next;
  logic                     res_fault;
  logic [REFMV_W-1:0]       ref_mv;
  logic [DIVD_W-1:0]        div_dvd;
  logic [DIVR_W-1:0]        div_dvs;
  logic                     div_busy, div_done;
  logic [DIVD_W-1:0]        div_q;
  kind_t                    kind_map;

  assign idx        = item_q.slot[IDX_W-1:0];
  assign newsum     = SUM_W'(sums[idx] + SUM_W'(item_q.sample));
  assign newcnt     = CNT_W'(cnts[idx] + CNT_W'(1));
  assign limit      = (cfg.samples_per_average == '0) ? CNT_W'(1) : cfg.samples_per_average;
  assign fs_minus_m = FULL_SCALE - m;
  assign kind_map   = (kinds[idx] > KIND_RAW) ? KIND_RAW : kind_t'(kinds[idx]);

  always_comb begin
    case (kind_q)
      KIND_POS_RES:   fault_now = (m == '0);
      KIND_NEG_RES:   fault_now = (m == FULL_SCALE);
      KIND_REFERENCE: fault_now = (m == '0);
      default:        fault_now = 1'b0;
    endcase
  end

  always_comb begin
    stat.slot_ok   = int'(item_q.slot) < SLOTS;
    stat.is_load   = (item_q.command == CMD_LOAD);
    stat.avg_done  = newcnt >= limit;
    stat.kind      = kind_q;
    stat.fault_now = fault_now;
    stat.div_done  = div_done;
    stat.out_free  = !result_valid || !result_stall;
  end

  // Input item register
  always_ff @(posedge clk) begin
    if (cmd.take_item) item_q <= item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) begin
        sums[i] <= '0;
        cnts[i] <= '0;
      end
    end else if (cmd.upd && stat.slot_ok && !stat.is_load) begin
      sums[idx] <= stat.avg_done ? '0 : newsum;
      cnts[idx] <= stat.avg_done ? '0 : newcnt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.upd && stat.slot_ok && stat.is_load) begin
      kinds[idx] <= item_q.channel_kind;
      gains[idx] <= item_q.gain;
      offs[idx]  <= item_q.offset_value;
    end
  end

  // Multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (cmd.mul_sel == MUL_OFFSET) begin
      mul_a = $signed({{(MUL_A_W-23){1'b0}}, q2[22:0]}) + $signed({{2{o_q[GAIN_W-1]}}, o_q});
      mul_b = g_q;
    end else begin
      case (kind_q)
        KIND_CURRENT, KIND_VOLTAGE: begin
          mul_a = $signed(MUL_A_W'(m));
          mul_b = $signed(GAIN_W'(ref_mv));
        end
        KIND_POS_RES: begin
          mul_a = $signed(MUL_A_W'(fs_minus_m));
          mul_b = g_q;
        end
        KIND_NEG_RES: begin
          mul_a = $signed(MUL_A_W'(m));
          mul_b = g_q;
        end
        KIND_REFERENCE: begin
          mul_a = $signed(MUL_A_W'(cfg.vref_cal_mv));
          mul_b = $signed(GAIN_W'(cfg.vref_factory_code));
        end
        default: ;
      endcase
    end
  end

  assign prod   = mul_a * mul_b;
  assign p1_mag = p1[MUL_P_W-1] ? -p1 : p1;

  // Divider operands
  always_comb begin
    div_dvd = '0;
    div_dvs = DIVR_W'(1);
    case (cmd.div_sel)
      DIV_MEAN: begin
        div_dvd = DIVD_W'(newsum);
        div_dvs = DIVR_W'(newcnt);
      end
      DIV_KIND: begin
        case (kind_q)
          KIND_CURRENT, KIND_VOLTAGE: begin
            div_dvd = {p1[DIVD_W-17:0], 16'b0};
            div_dvs = VOLT_DIV;
          end
          KIND_POS_RES: begin
            div_dvd = p1_mag[DIVD_W-1:0];
            div_dvs = DIVR_W'(m);
          end
          KIND_NEG_RES: begin
            div_dvd = p1_mag[DIVD_W-1:0];
            div_dvs = DIVR_W'(fs_minus_m);
          end
          KIND_REFERENCE: begin
            div_dvd = p1[DIVD_W-1:0];
            div_dvs = DIVR_W'(m);
          end
          default: ;
        endcase
      end
      DIV_MV: begin
        div_dvd = {q2[DIVD_W-17:0], 16'b0};
        div_dvs = MV_DIV;
      end
      default: ;
    endcase
  end

  acd_div #(.DW(DIVD_W), .RW(DIVR_W)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (cmd.upd) begin
      kind_q <= kind_map;
      g_q    <= gains[idx];
      o_q    <= offs[idx];
    end
    if (cmd.latch_m) m <= div_q[ADC_BITS-1:0];
    if (cmd.mul) begin
      p1 <= prod;
      if (cmd.mul_sel == MUL_FIRST) fault_q <= fault_now;
    end
    if (cmd.latch_q2) q2 <= div_q;
    if (cmd.scale) begin
      // Floor to whole units, then scale current by 1000 = 1024 - 16 - 8
      if (kind_q == KIND_CURRENT) scaled <= (sh64 <<< 10) - (sh64 <<< 4) - (sh64 <<< 3);
      else scaled <= sh64;
    end
  end

  assign sh64 = 64'($signed(p1[MUL_P_W-1:16]));

  always_ff @(posedge clk) begin
    if (rst) ref_mv <= REFMV_RESET;
    else if (cmd.ref_update) begin
      ref_mv <= (|q2[DIVD_W-1:REFMV_W]) ? '1 : q2[REFMV_W-1:0];
    end
  end

  assign q64      = {{(64-DIVD_W){1'b0}}, q2};
  assign o64      = {{(64-GAIN_W){o_q[GAIN_W-1]}}, o_q};
  assign signed_q = p1[MUL_P_W-1] ? -q64 : q64;

  always_comb begin
    if (fault_q) begin
      if (kind_q == KIND_REFERENCE) res_val_next = VAL_MAX;
      else res_val_next = g_q[GAIN_W-1] ? VAL_MIN : VAL_MAX;
    end else begin
      case (kind_q)
        KIND_CURRENT, KIND_VOLTAGE: res_val_next = sat_val(scaled);
        KIND_POS_RES, KIND_NEG_RES: res_val_next = sat_val(signed_q + o64);
        KIND_REFERENCE:             res_val_next = sat_val(q64);
        default: res_val_next = $signed({{(VAL_W-ADC_BITS-16){1'b0}}, m, 16'b0});
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      res_val   <= res_val_next;
      res_fault <= fault_q;
    end
  end

  // Output register: hold while stalled
  always_ff @(posedge clk) begin
    if (rst) result_valid <= 1'b0;
    else if (cmd.out_load) result_valid <= 1'b1;
    else if (!result_stall) result_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      result.out_slot     <= item_q.slot;
      result.value        <= res_val;
      result.divide_fault <= res_fault;
    end
  end

`ifndef SYNTHESIS
  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |-> !div_busy) else $error("divider started while busy");
  a_out_load: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |=> result_valid) else $error("result beat lost on load");
  a_fault_sat: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.divide_fault) |->
      (result.value == VAL_MAX || result.value == VAL_MIN))
    else $error("fault result not saturated");
`endif

endmodule

`default_nettype wire

### rtl/acd_ctrl.sv
// Controller state machine: sequences accept, averaging, conversion and output.
// Depends on acd_pkg.
`default_nettype none

module acd_ctrl
  import acd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       item_valid,
  output logic            item_stall,
  input  wire dp_status_t stat,
  output dp_cmd_t         cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    cmd.div_sel = DIV_MEAN;
    cmd.mul_sel = MUL_FIRST;
    item_stall = (state != ST_IDLE);
    case (state)
      ST_IDLE: begin
        if (item_valid) begin
          cmd.take_item = 1'b1;
          state_next = ST_UPD;
        end
      end
      ST_UPD: begin
        cmd.upd = 1'b1;
        if (stat.slot_ok && !stat.is_load && stat.avg_done) begin
          cmd.div_start = 1'b1;
          state_next = ST_MEAN;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_MEAN: begin
        if (stat.div_done) begin
          cmd.latch_m = 1'b1;
          state_next = ST_MUL1;
        end
      end
      ST_MUL1: begin
        cmd.mul = 1'b1;
        if (stat.fault_now || stat.kind == KIND_RAW) state_next = ST_RES;
        else state_next = ST_DIV2S;
      end
      ST_DIV2S: begin
        cmd.div_start = 1'b1;
        cmd.div_sel = DIV_KIND;
        state_next = ST_DIV2W;
      end
      ST_DIV2W: begin
        if (stat.div_done) begin
          cmd.latch_q2 = 1'b1;
          case (stat.kind)
            KIND_CURRENT, KIND_VOLTAGE: state_next = ST_MUL2;
            KIND_REFERENCE:             state_next = ST_DIV3S;
            default:                    state_next = ST_RES;
          endcase
        end
      end
      ST_MUL2: begin
        cmd.mul = 1'b1;
        cmd.mul_sel = MUL_OFFSET;
        state_next = ST_SCALE;
      end
      ST_SCALE: begin
        cmd.scale = 1'b1;
        state_next = ST_RES;
      end
      ST_DIV3S: begin
        // Quotient holds the new reference millivolts here
        cmd.ref_update = 1'b1;
        cmd.div_start = 1'b1;
        cmd.div_sel = DIV_MV;
        state_next = ST_DIV3W;
      end
      ST_DIV3W: begin
        if (stat.div_done) begin
          cmd.latch_q2 = 1'b1;
          state_next = ST_RES;
        end
      end
      ST_RES: begin
        cmd.res_load = 1'b1;
        state_next = ST_OUT;
      end
      ST_OUT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire
